FILE: rtl/core/sbfc_pkg.sv
// ----------------------------------------------------------------------------
// sbfc_pkg
// shared types and codes of the sound buffer frame capture block
// ----------------------------------------------------------------------------
package sbfc_pkg;

  // access kinds on the input side
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;

  // result kinds on the output side
  localparam logic [1:0] RESP_ACCESS = 2'd0;
  localparam logic [1:0] RESP_GROUP  = 2'd1;
  localparam logic [1:0] RESP_SILENT = 2'd2;

  localparam logic [7:0]  SAMPLE_MASK     = 8'h7f;
  localparam logic [7:0]  FILL_BYTE       = 8'h80;
  localparam logic [31:0] FILL_WORD       = {4{FILL_BYTE}};
  localparam logic [1:0]  COUNTDOWN_RESET = 2'd2;

  // one bus access
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] addr;
    logic [2:0]  length;
    logic [31:0] write_data;
  } req_t;

  // write-back of the two word banks
  typedef struct packed {
    logic        even_we;
    logic        odd_we;
    logic [31:0] even_wdata;
    logic [31:0] odd_wdata;
  } wr_t;

endpackage

FILE: rtl/core/sbfc_ram.sv
// ----------------------------------------------------------------------------
// sbfc_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sbfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 93
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sbfc_lane.sv
// ----------------------------------------------------------------------------
// sbfc_lane
// access check, bank row selection and big-endian byte merge of one access
// ----------------------------------------------------------------------------
module sbfc_lane #(
  parameter int BUFFER_BYTES = 740,
  parameter int ROWS         = 93,
  parameter int AW           = 7
) (
  input  sbfc_pkg::req_t   req,
  input  logic [31:0]      even_rdata,
  input  logic [31:0]      odd_rdata,
  output logic             ok,
  output logic [AW-1:0]    row_even,
  output logic [AW-1:0]    row_odd,
  output logic [31:0]      rd_data,
  output sbfc_pkg::wr_t    wr
);

  logic [AW-1:0] base;
  logic [AW:0]   base1;
  logic          hi_ok;
  logic [63:0]   pair;
  logic [63:0]   shifted;
  logic [63:0]   wd_al;
  logic [63:0]   mask;
  logic [63:0]   newp;
  logic [4:0]    sh;
  logic [4:0]    lsh;
  logic [1:0]    nlen;
  logic          is_wr;

  always_comb begin
    ok = (req.kind == sbfc_pkg::KIND_READ || req.kind == sbfc_pkg::KIND_WRITE) &&
         req.length >= 3'd1 && req.length <= 3'd4 &&
         ({1'b0, req.addr} + 25'(req.length)) <= 25'(BUFFER_BYTES);
    is_wr = ok && req.kind == sbfc_pkg::KIND_WRITE;

    // word w lives in bank w[0], row w >> 1
    base     = req.addr[AW+2:3];
    base1    = {1'b0, base} + (AW+1)'(1);
    hi_ok    = base1 < (AW+1)'(ROWS);
    row_odd  = base;
    row_even = req.addr[2] ? (hi_ok ? base1[AW-1:0] : '0) : base;

    pair = req.addr[2] ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};

    nlen = 2'(3'd4 - req.length);
    sh   = {req.addr[1:0], 3'b000};
    lsh  = {nlen, 3'b000};

    shifted = pair << sh;
    rd_data = shifted[63:32] >> lsh;

    wd_al = {req.write_data << lsh, 32'h0} >> sh;
    mask  = {32'hffff_ffff << lsh, 32'h0} >> sh;
    newp  = (pair & ~mask) | (wd_al & mask);

    if (req.addr[2]) begin
      wr.odd_wdata  = newp[63:32];
      wr.odd_we     = is_wr && (|mask[63:32]);
      wr.even_wdata = newp[31:0];
      wr.even_we    = is_wr && (|mask[31:0]);
    end else begin
      wr.even_wdata = newp[63:32];
      wr.even_we    = is_wr && (|mask[63:32]);
      wr.odd_wdata  = newp[31:0];
      wr.odd_we     = is_wr && (|mask[31:0]);
    end
  end

endmodule

FILE: rtl/core/sound_buffer_frame_capture.sv
// ----------------------------------------------------------------------------
// sound_buffer_frame_capture
// memory-mapped sound buffer with frame capture of the even-offset bytes
// ----------------------------------------------------------------------------
//
//  channel | ports                          | word
//  --------+--------------------------------+-----------------------------------
//  in      | in_tvalid/in_tready/in_tdata/  | one bus access (kind in tuser)
//          | in_tuser                       |
//  out     | out_tvalid/out_tready/out_tdata| access response, sample group or
//          | /out_tuser/out_tlast           | silent marker (kind in tuser)
//  cfg     | cfg_valid/cfg_ready/cfg_data   | output_enable
//
//  an access is accepted with the bank reads issued, then merged, written
//  back and its response loaded; the single read port per bank sets this order
//  a triggered frame walks ceil(FRAME_SAMPLES/4) row pairs, each read then
//  checked for silence; a loud frame walks them again for the groups, then
//  the access rows are read again before the access itself completes
//  after reset a clearing pass writes 0x80 to every row; result stalls hold the fsm
//
module sound_buffer_frame_capture #(
  parameter int BUFFER_BYTES  = 740,
  parameter int FRAME_SAMPLES = 370
) (
  input  logic         clk,
  input  logic         rst_n,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // addr[23:0], length[26:24], write_data[58:27]
  input  logic [1:0]   in_tuser,   // kind[1:0]
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // access_ok[0], read_data[32:1],
                                   // sample_group[96:33], group_count[100:97]
  output logic [1:0]   out_tuser,  // resp_kind[1:0]
  output logic         out_tlast,
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  // bank geometry: bytes 8r..8r+3 in the even bank row r, 8r+4..8r+7 in the odd
  localparam int ROWS     = (BUFFER_BYTES + 7) / 8;
  localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  // one row pair yields four samples
  localparam int NP       = (FRAME_SAMPLES + 3) / 4;
  localparam int PW       = $clog2(NP + 1);
  localparam int NG       = (FRAME_SAMPLES + 7) / 8;
  localparam int LAST_CNT = FRAME_SAMPLES - 8 * (NG - 1);
  localparam int IW       = PW + 2;
  localparam int BW       = $clog2(BUFFER_BYTES + 1);
  localparam int OW       = (IW + 1 > BW) ? IW + 1 : BW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_DAT,
    S_EMIT_RD,
    S_EMIT_DAT,
    S_SILENT,
    S_ACC_RD,
    S_ACC
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [PW-1:0]         pair_r, pair_nxt;
  logic [1:0]            cd_r, cd_nxt;
  logic                  enable_r, enable_nxt;
  logic                  silent_r, silent_nxt;
  logic [31:0]           grp_hi_r, grp_hi_nxt;
  sbfc_pkg::req_t        req_r, req_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [31:0]           out_rd_r, out_rd_nxt;
  logic [63:0]           out_grp_r, out_grp_nxt;
  logic [3:0]            out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;

  sbfc_pkg::req_t        in_req;
  sbfc_pkg::req_t        lane_req;
  sbfc_pkg::wr_t         lane_wr;
  logic                  lane_ok;
  logic [AW-1:0]         lane_row_even, lane_row_odd;
  logic [31:0]           lane_rd;

  logic [31:0]           even_rdata, odd_rdata;
  logic                  ram_re;
  logic [AW-1:0]         even_raddr, odd_raddr, walk_row;
  logic                  even_we, odd_we;
  logic [AW-1:0]         even_waddr, odd_waddr;
  logic [31:0]           even_wdata, odd_wdata;

  logic                  accept;
  logic                  slot_free;
  logic                  trig_zone;
  logic [7:0]            smp [4];
  logic [31:0]           cur4;
  logic                  quiet_all;
  logic                  last_pair;
  logic                  last_group;
  logic [IW-1:0]         sidx;
  logic [OW-1:0]         soff;
  logic [7:0]            sraw;

  assign in_req.kind       = in_tuser;
  assign in_req.addr       = in_tdata[23:0];
  assign in_req.length     = in_tdata[26:24];
  assign in_req.write_data = in_tdata[58:27];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // the lane sees the incoming access while idle so its bank reads go out
  // at accept; later it works on the held access
  assign lane_req = (state_r == S_IDLE) ? in_req : req_r;

  sbfc_lane #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ROWS         (ROWS),
    .AW           (AW)
  ) u_lane (
    .req        (lane_req),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata),
    .ok         (lane_ok),
    .row_even   (lane_row_even),
    .row_odd    (lane_row_odd),
    .rd_data    (lane_rd),
    .wr         (lane_wr)
  );

  // rows past the store are read as anything; their samples are replaced
  assign walk_row = (32'(pair_r) < 32'(ROWS)) ? AW'(pair_r) : '0;

  always_comb begin
    ram_re = 1'b0;
    unique case (state_r)
      S_IDLE:                          ram_re = accept;
      S_SCAN_RD, S_EMIT_RD, S_ACC_RD:  ram_re = 1'b1;
      default:                         ram_re = 1'b0;
    endcase
  end

  assign even_raddr = (state_r == S_SCAN_RD || state_r == S_EMIT_RD) ? walk_row
                                                                     : lane_row_even;
  assign odd_raddr  = (state_r == S_SCAN_RD || state_r == S_EMIT_RD) ? walk_row
                                                                     : lane_row_odd;

  // clearing pass fills both banks, otherwise the access write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_waddr = clr_r;
      odd_waddr  = clr_r;
      even_wdata = sbfc_pkg::FILL_WORD;
      odd_wdata  = sbfc_pkg::FILL_WORD;
    end else begin
      even_we    = (state_r == S_ACC) && slot_free && lane_wr.even_we;
      odd_we     = (state_r == S_ACC) && slot_free && lane_wr.odd_we;
      even_waddr = lane_row_even;
      odd_waddr  = lane_row_odd;
      even_wdata = lane_wr.even_wdata;
      odd_wdata  = lane_wr.odd_wdata;
    end
  end

  sbfc_ram #(.WIDTH(32), .DEPTH(ROWS)) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (ram_re),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  sbfc_ram #(.WIDTH(32), .DEPTH(ROWS)) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (ram_re),
    .raddr (odd_raddr),
    .rdata (odd_rdata)
  );

  // four samples of the current row pair: byte offsets 0 and 2 of each word
  always_comb begin
    quiet_all = 1'b1;
    sidx      = '0;
    soff      = '0;
    sraw      = '0;
    for (int k = 0; k < 4; k++) begin
      sidx = {pair_r, 2'(k)};
      soff = OW'({sidx, 1'b0});
      case (k)
        0:       sraw = even_rdata[31:24];
        1:       sraw = even_rdata[15:8];
        2:       sraw = odd_rdata[31:24];
        default: sraw = odd_rdata[15:8];
      endcase
      if (sidx >= IW'(FRAME_SAMPLES)) begin
        smp[k] = 8'h00;
      end else if (soff >= OW'(BUFFER_BYTES)) begin
        smp[k] = sbfc_pkg::FILL_BYTE;
      end else begin
        smp[k] = sraw;
      end
      quiet_all = quiet_all && ((smp[k] & sbfc_pkg::SAMPLE_MASK) == 8'h00);
    end
  end

  assign cur4       = {smp[0], smp[1], smp[2], smp[3]};
  assign last_pair  = (pair_r == PW'(NP - 1));
  assign last_group = ((pair_r >> 1) == PW'(NG - 1));
  assign trig_zone  = lane_ok && in_req.kind == sbfc_pkg::KIND_WRITE &&
                      {1'b0, in_req.addr} >= 25'(BUFFER_BYTES - 4);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pair_nxt      = pair_r;
    cd_nxt        = cd_r;
    enable_nxt    = cfg_valid ? cfg_data : enable_r;
    silent_nxt    = silent_r;
    grp_hi_nxt    = grp_hi_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    out_grp_nxt   = out_grp_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          state_nxt = S_ACC;
          // every second write into the last four bytes takes a frame first if enabled
          if (trig_zone) begin
            if (cd_r == 2'd1) begin
              cd_nxt = sbfc_pkg::COUNTDOWN_RESET;
              if (enable_r) begin
                pair_nxt   = '0;
                silent_nxt = 1'b1;
                state_nxt  = S_SCAN_RD;
              end
            end else begin
              cd_nxt = cd_r - 2'd1;
            end
          end
        end
      end

      S_SCAN_RD: state_nxt = S_SCAN_DAT;

      S_SCAN_DAT: begin
        silent_nxt = silent_r && quiet_all;
        if (last_pair) begin
          pair_nxt  = '0;
          state_nxt = (silent_r && quiet_all) ? S_SILENT : S_EMIT_RD;
        end else begin
          pair_nxt  = pair_r + PW'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_EMIT_RD: state_nxt = S_EMIT_DAT;

      S_EMIT_DAT: begin
        if (!pair_r[0] && !last_pair) begin
          grp_hi_nxt = cur4;
          pair_nxt   = pair_r + PW'(1);
          state_nxt  = S_EMIT_RD;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sbfc_pkg::RESP_GROUP;
          out_ok_nxt    = 1'b0;
          out_rd_nxt    = '0;
          out_grp_nxt   = pair_r[0] ? {grp_hi_r, cur4} : {cur4, 32'h0};
          out_cnt_nxt   = last_group ? 4'(LAST_CNT) : 4'd8;
          out_last_nxt  = 1'b0;
          if (last_pair) begin
            pair_nxt  = '0;
            state_nxt = S_ACC_RD;
          end else begin
            pair_nxt  = pair_r + PW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_SILENT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sbfc_pkg::RESP_SILENT;
          out_ok_nxt    = 1'b0;
          out_rd_nxt    = '0;
          out_grp_nxt   = '0;
          out_cnt_nxt   = '0;
          out_last_nxt  = 1'b0;
          state_nxt     = S_ACC_RD;
        end
      end

      // the walk overwrote the bank read data, fetch the access rows again
      S_ACC_RD: state_nxt = S_ACC;

      S_ACC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sbfc_pkg::RESP_ACCESS;
          out_ok_nxt    = lane_ok;
          out_rd_nxt    = (lane_ok && req_r.kind == sbfc_pkg::KIND_READ) ? lane_rd : '0;
          out_grp_nxt   = '0;
          out_cnt_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pair_r      <= '0;
      cd_r        <= sbfc_pkg::COUNTDOWN_RESET;
      enable_r    <= 1'b0;
      silent_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pair_r      <= pair_nxt;
      cd_r        <= cd_nxt;
      enable_r    <= enable_nxt;
      silent_r    <= silent_nxt;
      out_valid_r <= out_valid_nxt;
    end
    grp_hi_r   <= grp_hi_nxt;
    req_r      <= req_nxt;
    out_kind_r <= out_kind_nxt;
    out_ok_r   <= out_ok_nxt;
    out_rd_r   <= out_rd_nxt;
    out_grp_r  <= out_grp_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_grp_r, out_rd_r, out_ok_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // countdown only ever rests at one or two
  a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
    cd_r == 2'd1 || cd_r == 2'd2)
    else $error("trigger countdown out of range");

  // frame results never close an access
  a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != sbfc_pkg::RESP_ACCESS |-> !out_last_r)
    else $error("frame result marked last");

  // a refused access reports no read data
  a_fault_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == sbfc_pkg::RESP_ACCESS && !out_ok_r |-> out_rd_r == '0)
    else $error("bus fault carries read data");

  // banks are written only by the clearing pass or an access write-back
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    even_we || odd_we |-> state_r == S_CLEAR || state_r == S_ACC)
    else $error("bank written outside clear or access");

  // an access completes with its response loaded into the output register
  a_acc_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC && slot_free |=> out_valid_r && out_last_r)
    else $error("access left without response");

endmodule
